### rtl/core/chbc_pkg.sv
package chbc_pkg;

    localparam int unsigned MAX_CAL_SAMPLES = 1024;
    localparam int unsigned FRACTION_BITS   = 8;

    localparam logic [1:0] OP_DETECT = 2'd0;
    localparam logic [1:0] OP_CAL    = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_REPORT = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [11:0] FACTOR_RESET = 12'd51;
    localparam logic [23:0] COUNT_MAX    = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]          operation;
        logic signed [15:0]  axis_x;
        logic signed [15:0]  axis_y;
        logic signed [15:0]  axis_z;
    } t_req;

    typedef struct packed {
        logic [15:0] magnitude;
        logic        breath_seen;
        logic [23:0] reported_breaths;
        logic [15:0] low_level;
        logic [15:0] high_level;
        logic        levels_valid;
        logic [1:0]  status;
    } t_rsp;

    // One classified request passed from the front to the back.
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] magnitude;
    } t_job;

endpackage

### rtl/core/chbc_isqrt.sv
module chbc_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [53:0] i_value,
    output logic        o_done,
    output logic [26:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [53:0] r_val;
    logic [29:0] r_rem;
    logic [26:0] r_root;

    logic [29:0] rem_sh;
    logic [29:0] trial;
    logic        ge;

    // One result bit per cycle: bring down two radicand bits, try root*4+1.
    assign rem_sh = {r_rem[27:0], r_val[53:52]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_val  <= i_value;
                r_rem  <= 30'd0;
                r_root <= 27'd0;
            end else if (r_busy) begin
                r_val  <= {r_val[51:0], 2'b00};
                r_rem  <= ge ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[25:0], ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd26) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/core/chbc_front.sv
module chbc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  chbc_pkg::t_req i_req,
    output logic          o_stall,
    output logic          o_push,
    output chbc_pkg::t_job o_job,
    input  logic          i_full
);

    typedef enum logic [3:0] {
        F_IDLE   = 4'b0001,
        F_SQUARE = 4'b0010,
        F_ROOT   = 4'b0100,
        F_HOLD   = 4'b1000
    } t_fstate;

    t_fstate            r_state;
    logic [1:0]         r_op;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic [1:0]         r_sel;
    logic [33:0]        r_acc;
    logic [15:0]        r_mag;

    logic signed [15:0] axis;
    logic signed [31:0] square;
    logic               root_start;
    logic               root_done;
    logic [26:0]        root;

    always_comb begin
        unique case (r_sel)
            2'd0:    axis = r_x;
            2'd1:    axis = r_y;
            default: axis = r_z;
        endcase
    end

    assign square     = axis * axis;
    assign root_start = (r_state == F_SQUARE) && (r_sel == 2'd3);

    chbc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value ({20'd0, r_acc}),
        .o_done  (root_done),
        .o_root  (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_op  <= i_req.operation;
                        r_x   <= i_req.axis_x;
                        r_y   <= i_req.axis_y;
                        r_z   <= i_req.axis_z;
                        r_sel <= 2'd0;
                        r_acc <= 34'd0;
                        if (i_req.operation == chbc_pkg::OP_DETECT ||
                            i_req.operation == chbc_pkg::OP_CAL) begin
                            r_state <= F_SQUARE;
                        end else begin
                            r_mag   <= 16'd0;
                            r_state <= F_HOLD;
                        end
                    end
                end
                F_SQUARE: begin
                    if (r_sel == 2'd3) begin
                        r_state <= F_ROOT;
                    end else begin
                        r_acc <= r_acc + {2'b00, square};
                        r_sel <= r_sel + 2'd1;
                    end
                end
                F_ROOT: begin
                    if (root_done) begin
                        r_mag   <= root[15:0];
                        r_state <= F_HOLD;
                    end
                end
                F_HOLD: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_stall         = (r_state != F_IDLE);
    assign o_push          = (r_state == F_HOLD) && !i_full;
    assign o_job.operation = r_op;
    assign o_job.magnitude = r_mag;

endmodule

### rtl/core/chbc_queue.sv
module chbc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  chbc_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output chbc_pkg::t_job o_job
);

    chbc_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

endmodule

### rtl/core/chbc_back.sv
module chbc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  chbc_pkg::t_job i_job,
    output logic           o_pop,
    input  logic [11:0]    i_factor,
    output logic           o_valid,
    output chbc_pkg::t_rsp o_rsp,
    input  logic           i_stall
);

    typedef enum logic [7:0] {
        B_IDLE   = 8'b0000_0001,
        B_MUL    = 8'b0000_0010,
        B_DIFF   = 8'b0000_0100,
        B_ROOT   = 8'b0000_1000,
        B_DIVM   = 8'b0001_0000,
        B_DIVD   = 8'b0010_0000,
        B_SPREAD = 8'b0100_0000,
        B_DONE   = 8'b1000_0000
    } t_bstate;

    localparam int unsigned FB = chbc_pkg::FRACTION_BITS;

    t_bstate        r_state;
    logic           r_above;
    logic           r_known;
    logic [23:0]    r_count;
    logic [15:0]    r_low;
    logic [15:0]    r_high;
    logic           r_ok;
    logic [10:0]    r_cal_count;
    logic [26:0]    r_cal_sum;
    logic [42:0]    r_cal_sq;
    logic [15:0]    r_cal_min;
    logic [15:0]    r_cal_max;
    logic           r_out_valid;
    chbc_pkg::t_rsp r_out;
    logic [53:0]    r_sq;
    logic [53:0]    r_prod;
    logic [53:0]    r_mq;
    logic [10:0]    r_mn;
    logic [5:0]     r_step;
    logic [10:0]    r_div_rem;
    logic [34:0]    r_div_quo;
    logic [23:0]    r_mean;
    logic [23:0]    r_dev;
    logic [35:0]    r_spread;

    logic        out_free;
    logic [15:0] mag;
    logic [31:0] mag_sq;
    logic        crossed;
    logic        cal_full;
    logic [53:0] diff;
    logic        root_done;
    logic [26:0] root;
    logic [11:0] div_t;
    logic        div_ge;
    logic [10:0] div_rem_n;
    logic [34:0] div_quo_n;
    logic [31:0] centre;
    logic        spread_over;
    logic [35:0] lo_diff;
    logic [36:0] hi_sum;
    logic [15:0] lo_raw;
    logic [20:0] hi_raw;
    logic [15:0] lo;
    logic [15:0] hi;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == B_IDLE) && !i_empty && out_free;
    assign mag      = i_job.magnitude;
    assign mag_sq   = 32'(mag) * 32'(mag);
    assign crossed  = r_above ? (mag < r_low) : (mag > r_high);
    assign cal_full = r_cal_count >= 11'(chbc_pkg::MAX_CAL_SAMPLES);

    // The variance numerator cannot go negative in exact arithmetic; clamp anyway.
    assign diff = (r_prod > r_sq) ? (r_prod - r_sq) : 54'd0;

    chbc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == B_DIFF),
        .i_value (diff),
        .o_done  (root_done),
        .o_root  (root)
    );

    // Restoring divider by the sample count, one quotient bit per cycle.
    assign div_t     = {r_div_rem, r_div_quo[34]};
    assign div_ge    = div_t >= {1'b0, r_cal_count};
    assign div_rem_n = div_ge ? 11'(div_t - {1'b0, r_cal_count}) : div_t[10:0];
    assign div_quo_n = {r_div_quo[33:0], div_ge};

    assign centre      = {r_mean, FB'(0)};
    assign spread_over = r_spread > {4'd0, centre};
    assign lo_diff     = {4'd0, centre} - r_spread;
    assign hi_sum      = {5'd0, centre} + {1'b0, r_spread};
    assign lo_raw      = lo_diff[2*FB +: 16];
    assign hi_raw      = hi_sum[2*FB +: 21];

    always_comb begin
        if (spread_over || lo_raw < r_cal_min) begin
            lo = r_cal_min;
        end else begin
            lo = lo_raw;
        end
        if (hi_raw > {5'd0, r_cal_max}) begin
            hi = r_cal_max;
        end else begin
            hi = hi_raw[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_above     <= 1'b0;
            r_known     <= 1'b0;
            r_count     <= 24'd0;
            r_low       <= 16'd0;
            r_high      <= 16'd0;
            r_ok        <= 1'b0;
            r_cal_count <= 11'd0;
            r_cal_sum   <= 27'd0;
            r_cal_sq    <= 43'd0;
            r_cal_min   <= 16'hFFFF;
            r_cal_max   <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_out.magnitude        <= 16'd0;
                        r_out.breath_seen      <= 1'b0;
                        r_out.reported_breaths <= 24'd0;
                        r_out.low_level        <= r_low;
                        r_out.high_level       <= r_high;
                        r_out.levels_valid     <= r_ok;
                        r_out.status           <= chbc_pkg::STATUS_OK;
                        r_out_valid            <= 1'b1;
                        unique case (i_job.operation)
                            chbc_pkg::OP_DETECT: begin
                                r_out.magnitude <= mag;
                                r_known         <= 1'b1;
                                if (crossed) begin
                                    r_above <= !r_above;
                                    // Only an upward crossing after the first sample counts.
                                    if (!r_above && r_known) begin
                                        r_out.breath_seen <= 1'b1;
                                        if (r_count != chbc_pkg::COUNT_MAX) begin
                                            r_count <= r_count + 24'd1;
                                        end
                                    end
                                end
                            end
                            chbc_pkg::OP_CAL: begin
                                r_out.magnitude <= mag;
                                if (cal_full) begin
                                    r_out.status <= chbc_pkg::STATUS_FULL;
                                end else begin
                                    r_cal_count <= r_cal_count + 11'd1;
                                    r_cal_sum   <= r_cal_sum + {11'd0, mag};
                                    r_cal_sq    <= r_cal_sq + {11'd0, mag_sq};
                                    if (mag < r_cal_min) r_cal_min <= mag;
                                    if (mag > r_cal_max) r_cal_max <= mag;
                                end
                            end
                            chbc_pkg::OP_FINISH: begin
                                if (r_cal_count == 11'd0) begin
                                    r_out.status <= chbc_pkg::STATUS_EMPTY;
                                end else begin
                                    r_out_valid <= 1'b0;
                                    r_sq        <= r_cal_sum * r_cal_sum;
                                    r_prod      <= 54'd0;
                                    r_mq        <= {11'd0, r_cal_sq};
                                    r_mn        <= r_cal_count;
                                    r_step      <= 6'd0;
                                    r_state     <= B_MUL;
                                end
                            end
                            default: begin
                                r_out.reported_breaths <= r_count;
                                r_count                <= 24'd0;
                            end
                        endcase
                    end
                end
                B_MUL: begin
                    if (r_mn[0]) begin
                        r_prod <= r_prod + r_mq;
                    end
                    r_mq   <= {r_mq[52:0], 1'b0};
                    r_mn   <= {1'b0, r_mn[10:1]};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd10) begin
                        r_state <= B_DIFF;
                    end
                end
                B_DIFF: begin
                    r_state <= B_ROOT;
                end
                B_ROOT: begin
                    if (root_done) begin
                        r_div_rem <= 11'd0;
                        r_div_quo <= {r_cal_sum, FB'(0)};
                        r_step    <= 6'd0;
                        r_state   <= B_DIVM;
                    end
                end
                B_DIVM: begin
                    r_div_rem <= div_rem_n;
                    r_div_quo <= div_quo_n;
                    r_step    <= r_step + 6'd1;
                    if (r_step == 6'd34) begin
                        r_mean    <= div_quo_n[23:0];
                        r_div_rem <= 11'd0;
                        r_div_quo <= {root, FB'(0)};
                        r_step    <= 6'd0;
                        r_state   <= B_DIVD;
                    end
                end
                B_DIVD: begin
                    r_div_rem <= div_rem_n;
                    r_div_quo <= div_quo_n;
                    r_step    <= r_step + 6'd1;
                    if (r_step == 6'd34) begin
                        r_dev   <= div_quo_n[23:0];
                        r_state <= B_SPREAD;
                    end
                end
                B_SPREAD: begin
                    r_spread <= i_factor * r_dev;
                    r_state  <= B_DONE;
                end
                B_DONE: begin
                    if (out_free) begin
                        r_low                  <= lo;
                        r_high                 <= hi;
                        r_ok                   <= (lo != hi);
                        r_cal_count            <= 11'd0;
                        r_cal_sum              <= 27'd0;
                        r_cal_sq               <= 43'd0;
                        r_cal_min              <= 16'hFFFF;
                        r_cal_max              <= 16'd0;
                        r_out.magnitude        <= 16'd0;
                        r_out.breath_seen      <= 1'b0;
                        r_out.reported_breaths <= 24'd0;
                        r_out.low_level        <= lo;
                        r_out.high_level       <= hi;
                        r_out.levels_valid     <= (lo != hi);
                        r_out.status           <= chbc_pkg::STATUS_OK;
                        r_out_valid            <= 1'b1;
                        r_state                <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

`ifndef SYNTHESIS
    a_cal_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal_count <= 11'(chbc_pkg::MAX_CAL_SAMPLES))
        else $error("calibration count beyond limit");

    a_ok_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ok |-> (r_low != r_high))
        else $error("levels valid with equal thresholds");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cal_count != 11'd0) |-> (r_cal_min <= r_cal_max))
        else $error("calibration minimum above maximum");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DONE && out_free) |=> (r_cal_count == 11'd0 && r_out_valid))
        else $error("finish did not clear accumulators or post a result");
`endif

endmodule

### rtl/core/calibrated_hysteresis_breath_counter.sv
// Breath counter on three-axis samples. A front end takes each request; for detect and
// calibrate requests it forms the magnitude (three squares, then a bit-serial square
// root), while finish and report requests pass it without a magnitude. It takes no new
// request until the last one is pushed into a two-entry queue, which carries each request
// to a back end that updates the hysteresis comparator, the calibration sums or the breath
// count. A finish with samples holds the back end for a shift-add product, a bit-serial
// square root and two restoring divisions by the sample count; once the queue fills, the
// front end stalls behind it.
// The hysteresis factor register sits at address 0 and must be written while idle.
module calibrated_hysteresis_breath_counter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  chbc_pkg::t_req i_req,
    output logic           o_stall,
    output logic           o_valid,
    output chbc_pkg::t_rsp o_rsp,
    input  logic           i_stall,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [11:0]    r_factor;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    chbc_pkg::t_job front_job;
    chbc_pkg::t_job back_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= chbc_pkg::FACTOR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_factor <= pwdata[11:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {20'd0, r_factor} : 32'd0;

    chbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_stall (o_stall),
        .o_push  (push),
        .o_job   (front_job),
        .i_full  (full)
    );

    chbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (back_job)
    );

    chbc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_job    (back_job),
        .o_pop    (pop),
        .i_factor (r_factor),
        .o_valid  (o_valid),
        .o_rsp    (o_rsp),
        .i_stall  (i_stall)
    );

endmodule

### bench/tb_calibrated_hysteresis_breath_counter.sv
`timescale 1ns / 1ps

module tb_calibrated_hysteresis_breath_counter;

    localparam int unsigned IDLE_LIMIT = 20000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    chbc_pkg::t_req i_req;
    logic           o_stall;
    logic           o_valid;
    chbc_pkg::t_rsp o_rsp;
    logic           i_stall;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    calibrated_hysteresis_breath_counter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted block state
    logic [11:0] factor;
    logic        above;
    logic        known;
    logic [23:0] breaths;
    logic [15:0] lo_thr;
    logic [15:0] hi_thr;
    logic        thr_ok;
    logic [63:0] n_cal;
    logic [63:0] sum_cal;
    logic [63:0] sq_cal;
    logic [15:0] min_cal;
    logic [15:0] max_cal;

    chbc_pkg::t_req pending_reqs[$];
    chbc_pkg::t_rsp expected_rsps[$];

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    bit          hold_sender;
    bit          failed;
    int unsigned idle_cycles;

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] mag_of(input chbc_pkg::t_req r);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic [63:0]        root;
        x = r.axis_x;
        y = r.axis_y;
        z = r.axis_z;
        root = isqrt(x * x + y * y + z * z);
        return root[15:0];
    endfunction

    task automatic reset_sums();
        n_cal = 0;
        sum_cal = 0;
        sq_cal = 0;
        min_cal = 16'hFFFF;
        max_cal = 16'd0;
    endtask

    task automatic finish_levels();
        logic [63:0] prod;
        logic [63:0] sq;
        logic [63:0] d;
        logic [63:0] mean_q;
        logic [63:0] dev_q;
        logic [63:0] spread;
        logic [63:0] centre;
        logic [63:0] lo;
        logic [63:0] hi;
        prod = n_cal * sq_cal;
        sq = sum_cal * sum_cal;
        d = (prod > sq) ? prod - sq : 64'd0;
        mean_q = (sum_cal << chbc_pkg::FRACTION_BITS) / n_cal;
        dev_q = (isqrt(d) << chbc_pkg::FRACTION_BITS) / n_cal;
        spread = 64'(factor) * dev_q;
        centre = mean_q << chbc_pkg::FRACTION_BITS;
        if (spread > centre) begin
            lo = 64'(min_cal);
        end else begin
            lo = (centre - spread) >> (2 * chbc_pkg::FRACTION_BITS);
            if (lo < 64'(min_cal)) lo = 64'(min_cal);
        end
        hi = (centre + spread) >> (2 * chbc_pkg::FRACTION_BITS);
        if (hi > 64'(max_cal)) hi = 64'(max_cal);
        lo_thr = lo[15:0];
        hi_thr = hi[15:0];
        thr_ok = (lo_thr != hi_thr);
        reset_sums();
    endtask

    task automatic predict_breath(input chbc_pkg::t_req r);
        chbc_pkg::t_rsp e;
        logic [15:0]    m;
        e = '0;
        e.status = chbc_pkg::STATUS_OK;
        case (r.operation)
            chbc_pkg::OP_DETECT: begin
                m = mag_of(r);
                e.magnitude = m;
                if ((above && m < lo_thr) || (!above && m > hi_thr)) begin
                    above = !above;
                    if (above && known) begin
                        e.breath_seen = 1'b1;
                        if (breaths != chbc_pkg::COUNT_MAX) breaths = breaths + 24'd1;
                    end
                end
                known = 1'b1;
            end
            chbc_pkg::OP_CAL: begin
                m = mag_of(r);
                e.magnitude = m;
                if (n_cal >= chbc_pkg::MAX_CAL_SAMPLES) begin
                    e.status = chbc_pkg::STATUS_FULL;
                end else begin
                    n_cal = n_cal + 64'd1;
                    sum_cal = sum_cal + 64'(m);
                    sq_cal = sq_cal + 64'(m) * 64'(m);
                    if (m < min_cal) min_cal = m;
                    if (m > max_cal) max_cal = m;
                end
            end
            chbc_pkg::OP_FINISH: begin
                if (n_cal == 0) e.status = chbc_pkg::STATUS_EMPTY;
                else finish_levels();
            end
            default: begin
                e.reported_breaths = breaths;
                breaths = '0;
            end
        endcase
        e.low_level = lo_thr;
        e.high_level = hi_thr;
        e.levels_valid = thr_ok;
        expected_rsps.push_back(e);
    endtask

    always #5 i_clk = ~i_clk;

    // Request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_breath(i_req);
                void'(pending_reqs.pop_front());
            end
            if (!(i_valid && o_stall)) begin
                if (pending_reqs.size() != 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_req <= pending_reqs[0];
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Response monitor and watchdog
    always @(posedge i_clk) begin
        chbc_pkg::t_rsp e;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
            if (o_valid && !i_stall) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, o_rsp);
                    failed = 1'b1;
                end else begin
                    e = expected_rsps.pop_front();
                    if (o_rsp !== e) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, o_rsp);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    function automatic chbc_pkg::t_req mk(input logic [1:0] op, input int x, input int y,
                                          input int z);
        chbc_pkg::t_req r;
        r.operation = op;
        r.axis_x = x[15:0];
        r.axis_y = y[15:0];
        r.axis_z = z[15:0];
        return r;
    endfunction

    function automatic chbc_pkg::t_req rand_req(input logic [1:0] op, input int unsigned base,
                                                input int unsigned noise);
        chbc_pkg::t_req r;
        r.operation = op;
        if (base == 0) begin
            r.axis_x = 16'($urandom);
            r.axis_y = 16'($urandom);
            r.axis_z = 16'($urandom);
        end else begin
            r.axis_x = 16'(base + $urandom_range(noise));
            r.axis_y = 16'($urandom_range(noise));
            r.axis_z = -$signed({1'b0, 15'($urandom_range(noise))});
        end
        return r;
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_factor(input logic [11:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        factor = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // One calibration of n samples around base, a finish, then a breathing pattern.
    task automatic breathing_set(input int unsigned n, input int unsigned base);
        int unsigned amp;
        amp = $urandom_range(4000, 50);
        for (int i = 0; i < n; i++)
            pending_reqs.push_back(rand_req(chbc_pkg::OP_CAL, base, amp));
        pending_reqs.push_back(mk(chbc_pkg::OP_FINISH, 0, 0, 0));
        for (int i = 0; i < 14; i++) begin
            pending_reqs.push_back(rand_req(chbc_pkg::OP_DETECT,
                                            (i % 4 < 2) ? base + 3 * amp : base,
                                            amp / 4 + 1));
            if ($urandom_range(19) == 0)
                pending_reqs.push_back(rand_req(chbc_pkg::OP_DETECT, 0, 0));
        end
        if ($urandom_range(2) == 0) pending_reqs.push_back(mk(chbc_pkg::OP_REPORT, 0, 0, 0));
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_sender = 1'b0;
        failed = 1'b0;
        idle_cycles = 0;
        factor = chbc_pkg::FACTOR_RESET;
        above = 1'b0;
        known = 1'b0;
        breaths = '0;
        lo_thr = '0;
        hi_thr = '0;
        thr_ok = 1'b0;
        reset_sums();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty finish, detect before calibration, axis extremes.
        pending_reqs.push_back(mk(chbc_pkg::OP_FINISH, 0, 0, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_DETECT, 5, 0, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_DETECT, 0, 0, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_DETECT, -32768, -32768, -32768));
        pending_reqs.push_back(mk(chbc_pkg::OP_REPORT, 0, 0, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_CAL, 32767, 32767, 32767));
        pending_reqs.push_back(mk(chbc_pkg::OP_CAL, -32768, 0, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_CAL, 3, 4, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_FINISH, 0, 0, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_CAL, 7, 7, 7));
        pending_reqs.push_back(mk(chbc_pkg::OP_FINISH, 0, 0, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_DETECT, 100, 0, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_DETECT, 0, 0, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_DETECT, 100, 0, 0));
        pending_reqs.push_back(mk(chbc_pkg::OP_REPORT, 1, -1, 1));
        drain();

        // Fill calibration past its limit; factor at maximum.
        write_factor(12'hFFF);
        for (int i = 0; i < chbc_pkg::MAX_CAL_SAMPLES + 3; i++)
            pending_reqs.push_back(rand_req(chbc_pkg::OP_CAL, 20000, 3000));
        pending_reqs.push_back(mk(chbc_pkg::OP_FINISH, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  write_factor(12'd0);  end
                1: begin
                    send_idle_pct = 83; stall_pct = 0;
                    write_factor(chbc_pkg::FACTOR_RESET);
                end
                2: begin send_idle_pct = 0;  stall_pct = 83; write_factor(12'd256); end
                3: begin send_idle_pct = 17; stall_pct = 17; write_factor(12'($urandom)); end
                default: begin send_idle_pct = 0; stall_pct = 0; write_factor(12'd700); end
            endcase
            for (int s = 0; s < 4; s++) begin
                breathing_set($urandom_range(12, 2), $urandom_range(30000, 500));
                if ($urandom_range(3) == 0) pending_reqs.push_back(rand_req(2'($urandom), 0, 0));
            end
            if (ph == 2) begin
                hold_sender = 1'b1;
                while (expected_rsps.size() != 0 || i_valid) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        if (failed) begin
            $display("Simulation FAILED");
        end else begin
            $display("Simulation PASSED");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/chbc_pkg.sv
rtl/core/chbc_isqrt.sv
rtl/core/chbc_front.sv
rtl/core/chbc_queue.sv
rtl/core/chbc_back.sv
rtl/core/calibrated_hysteresis_breath_counter.sv
bench/tb_calibrated_hysteresis_breath_counter.sv
